// File: hdl/fbss_pkg.sv
// Shared types, constants and matching functions for the fenced block stream splitter.
// Used by fbss_match, fbss_emit and fenced_block_stream_splitter.
`timescale 1ns / 1ps

package fbss_pkg;

    // Fence geometry
    localparam int FENCE_MAX = 8;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 3;

    // Burst marker: no byte of the burst is a block byte
    localparam logic [LEN_W-1:0] BLK_NONE = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] REG_START_FENCE = 2'd0;
    localparam logic [1:0] REG_START_LEN   = 2'd1;
    localparam logic [1:0] REG_END_FENCE   = 2'd2;
    localparam logic [1:0] REG_END_LEN     = 2'd3;

    // Input opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOS  = 1'b1;

    // Reset configuration: three backquotes
    localparam logic [63:0]      FENCE_RESET = 64'h0000_0000_0060_6060;
    localparam logic [LEN_W-1:0] LEN_RESET   = 4'd3;

    typedef struct packed {
        logic [63:0]      start_fence;
        logic [LEN_W-1:0] start_len;
        logic [63:0]      end_fence;
        logic [LEN_W-1:0] end_len;
    } fbss_cfg_t;

    // All results caused by one input item
    typedef struct packed {
        logic [7:0][7:0]  bytes;
        logic [LEN_W-1:0] count;     // 0..8 results
        logic [LEN_W-1:0] blk_from;  // first block byte index, BLK_NONE if none
        logic             closed;    // last result closes a block
        logic             eos;       // last result is the end marker
        logic             unterm;    // stream ended inside a block
    } fbss_burst_t;

    // Length 0 acts as 1, lengths above FENCE_MAX saturate
    function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] r;
        if (len == '0)
            r = 4'd1;
        else if (len > LEN_W'(FENCE_MAX))
            r = LEN_W'(FENCE_MAX);
        else
            r = len;
        return r;
    endfunction

    function automatic logic [7:0] fence_byte(logic [63:0] fence, logic [CNT_W-1:0] i);
        return fence[{i, 3'b000} +: 8];
    endfunction

    // Longest suffix of (fence[0..k-1], c) equal to a fence prefix, at most len bytes
    function automatic logic [LEN_W-1:0] fence_overlap(logic [63:0] fence,
                                                       logic [LEN_W-1:0] len,
                                                       logic [CNT_W-1:0] k,
                                                       logic [7:0] c);
        logic [LEN_W-1:0] best;
        logic             ok;
        logic [CNT_W-1:0] p;
        best = '0;
        for (int j = 1; j <= FENCE_MAX; j++) begin
            ok = (j <= int'(len)) && (j <= int'(k) + 1)
                 && (fence_byte(fence, CNT_W'(j - 1)) == c);
            for (int i = 0; i < FENCE_MAX - 1; i++) begin
                p = CNT_W'(int'(k) - j + 1 + i);
                if (i < j - 1)
                    ok = ok && (fence_byte(fence, p) == fence_byte(fence, CNT_W'(i)));
            end
            if (ok)
                best = LEN_W'(j);
        end
        return best;
    endfunction

endpackage

// File: hdl/fbss_match.sv
// Match state and burst builder: holds the fence match counts and block flag,
// and turns one registered input item into a burst of results. Uses fbss_pkg.
`timescale 1ns / 1ps

module fbss_match (
    input  logic                clk,
    input  logic                rst_n,
    input  fbss_pkg::fbss_cfg_t cfg,
    input  logic                opcode,
    input  logic [7:0]          in_byte,
    input  logic                advance,
    output fbss_pkg::fbss_burst_t burst
);
    import fbss_pkg::*;

    logic [CNT_W-1:0] start_cnt_reg, start_cnt_next;
    logic [CNT_W-1:0] end_cnt_reg, end_cnt_next;
    logic             inside_reg, inside_next;

    logic [LEN_W-1:0] ls, le;
    logic [CNT_W-1:0] k, ke;
    logic [LEN_W-1:0] ms, me;
    logic [LEN_W-1:0] total;

    // Effective lengths and counts cut to length-1
    always_comb
    begin
        ls = eff_len(cfg.start_len);
        le = eff_len(cfg.end_len);
        k  = ({1'b0, start_cnt_reg} >= ls) ? CNT_W'(ls - 4'd1) : start_cnt_reg;
        ke = ({1'b0, end_cnt_reg} >= le) ? CNT_W'(le - 4'd1) : end_cnt_reg;
        ms = fence_overlap(cfg.start_fence, ls, k, in_byte);
        me = fence_overlap(cfg.end_fence, le, ke, in_byte);
        total = {1'b0, k} + 4'd1;
    end

    // Burst contents and next match state
    always_comb
    begin
        for (int i = 0; i < FENCE_MAX; i++)
            burst.bytes[i] = (CNT_W'(i) == k) ? in_byte
                                              : fence_byte(cfg.start_fence, CNT_W'(i));
        burst.count    = '0;
        burst.blk_from = BLK_NONE;
        burst.closed   = 1'b0;
        burst.eos      = 1'b0;
        burst.unterm   = 1'b0;
        start_cnt_next = start_cnt_reg;
        end_cnt_next   = end_cnt_reg;
        inside_next    = inside_reg;

        if (opcode == OP_EOS) begin
            // held prefix bytes as text, then the marker
            burst.eos      = 1'b1;
            burst.unterm   = inside_reg;
            burst.count    = inside_reg ? 4'd1 : total;
            start_cnt_next = '0;
            end_cnt_next   = '0;
            inside_next    = 1'b0;
        end else if (!inside_reg) begin
            if (ms == ls) begin
                // start fence complete: leading text, then fence as block bytes
                burst.count    = total;
                burst.blk_from = total - ls;
                inside_next    = 1'b1;
                start_cnt_next = '0;
                end_cnt_next   = '0;
            end else begin
                burst.count    = total - ms;
                start_cnt_next = CNT_W'(ms);
            end
        end else begin
            // inside a block: byte goes out at once
            burst.bytes[0] = in_byte;
            burst.count    = 4'd1;
            burst.blk_from = '0;
            if (me == le) begin
                burst.closed   = 1'b1;
                inside_next    = 1'b0;
                start_cnt_next = '0;
                end_cnt_next   = '0;
            end else begin
                end_cnt_next = CNT_W'(me);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_cnt_reg <= '0;
            end_cnt_reg   <= '0;
            inside_reg    <= 1'b0;
        end else if (advance) begin
            start_cnt_reg <= start_cnt_next;
            end_cnt_reg   <= end_cnt_next;
            inside_reg    <= inside_next;
        end
    end

endmodule

// File: hdl/fbss_emit.sv
// Result sequencer: holds one burst and presents its results one per cycle while
// out_ready is high on the output channel. Uses fbss_pkg.
`timescale 1ns / 1ps

module fbss_emit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fbss_pkg::fbss_burst_t burst,
    input  logic                  load,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  in_block,
    output logic                  block_closed,
    output logic                  end_marker,
    output logic                  unterminated,
    output logic                  last
);
    import fbss_pkg::*;

    logic        valid_reg;
    logic [CNT_W-1:0] idx_reg;
    fbss_burst_t burst_reg;
    logic        is_last;
    logic        marker;
    logic        done;

    // Position within the burst
    always_comb
    begin
        is_last = ({1'b0, idx_reg} == (burst_reg.count - 4'd1));
        marker  = burst_reg.eos && is_last;
        done    = valid_reg && out_ready && is_last;
        free    = !valid_reg || done;
    end

    // Output fields
    always_comb
    begin
        out_valid    = valid_reg;
        out_byte     = marker ? 8'd0 : burst_reg.bytes[idx_reg];
        in_block     = !marker && ({1'b0, idx_reg} >= burst_reg.blk_from);
        block_closed = burst_reg.closed && is_last;
        end_marker   = marker;
        unterminated = burst_reg.unterm && marker;
        last         = is_last;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (done) begin
            valid_reg <= 1'b0;
        end else if (valid_reg && out_ready) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    // Burst payload
    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst;
    end

endmodule

// File: hdl/fenced_block_stream_splitter.sv
// Top level: configuration registers, input register, match unit, result sequencer.
// Depends on fbss_pkg, fbss_match and fbss_emit.
// Path from input accept to the first result: input register, then the sequencer.
// Throughput: one result per cycle while out_ready is high; an item has 0 to 8
// results, and single-result items flow at 1 per cycle while out_ready is high.
// Reset: match counts and block flag cleared, both fences set to three
// backquotes with length 3. No clearing pass.
`timescale 1ns / 1ps

module fenced_block_stream_splitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        in_block,
    output logic        block_closed,
    output logic        end_marker,
    output logic        unterminated,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import fbss_pkg::*;

    fbss_cfg_t   cfg_reg;
    logic        item_valid_reg;
    logic        item_op_reg;
    logic [7:0]  item_byte_reg;
    fbss_burst_t burst;
    logic        emit_free;
    logic        consume;
    logic        load;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.start_fence <= FENCE_RESET;
            cfg_reg.start_len   <= LEN_RESET;
            cfg_reg.end_fence   <= FENCE_RESET;
            cfg_reg.end_len     <= LEN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_FENCE: cfg_reg.start_fence <= cfg_data;
                REG_START_LEN:   cfg_reg.start_len   <= cfg_data[LEN_W-1:0];
                REG_END_FENCE:   cfg_reg.end_fence   <= cfg_data;
                REG_END_LEN:     cfg_reg.end_len     <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Item leaves the input register when its burst can load (or it has none)
    always_comb
    begin
        consume  = item_valid_reg && ((burst.count == '0) || emit_free);
        load     = consume && (burst.count != '0);
        in_ready = !item_valid_reg || consume;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            item_op_reg   <= opcode;
            item_byte_reg <= in_byte;
        end
    end

    fbss_match u_match (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .opcode  (item_op_reg),
        .in_byte (item_byte_reg),
        .advance (consume),
        .burst   (burst)
    );

    fbss_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .burst        (burst),
        .load         (load),
        .free         (emit_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .in_block     (in_block),
        .block_closed (block_closed),
        .end_marker   (end_marker),
        .unterminated (unterminated),
        .last         (last)
    );

endmodule

// File: hdl/fbss_checker.sv
// Port-level checks for the fenced block stream splitter, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module fbss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       in_block,
    input logic       block_closed,
    input logic       end_marker,
    input logic       unterminated,
    input logic       last
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("result changed while stalled");

    // End marker closes the request's results and carries no byte
    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_marker |-> last && (out_byte == 8'd0) && !in_block)
        else $error("bad end marker");

    // Block close is the last result and a block byte
    a_close_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_closed |-> in_block && last && !end_marker)
        else $error("bad block close");

    // Unterminated flag only on the end marker
    a_unterm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && unterminated |-> end_marker)
        else $error("unterminated outside end marker");

endmodule

bind fenced_block_stream_splitter fbss_checker u_fbss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .in_block     (in_block),
    .block_closed (block_closed),
    .end_marker   (end_marker),
    .unterminated (unterminated),
    .last         (last)
);

// File: verif/fence_split_checker.sv
// Scoreboard for the fenced block stream splitter: watches the request, result
// and register channels, predicts every result and compares it on arrival.
// Depends on fbss_pkg for register indexes, opcodes and reset values.
`timescale 1ns / 1ps

module fence_split_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        opcode,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        in_block,
    input  logic        block_closed,
    input  logic        end_marker,
    input  logic        unterminated,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          result_total,
    output int          closed_total,
    output int          marker_total
);
    import fbss_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       blk;
        logic       closed;
        logic       eos;
        logic       unterm;
        logic       lst;
    } split_result_t;

    // Results still owed by the block, oldest first
    split_result_t expected_q[$];

    // Shadow registers and splitter state
    logic [63:0] start_pat;
    logic [63:0] end_pat;
    logic [3:0]  start_len_reg;
    logic [3:0]  end_len_reg;
    int          held_cnt;
    int          end_cnt;
    bit          in_fenced;

    // Zero acts as one, anything past the fence width saturates
    function automatic int act_len(logic [3:0] len);
        if (len == 4'd0)
            return 1;
        if (int'(len) > FENCE_MAX)
            return FENCE_MAX;
        return int'(len);
    endfunction

    function automatic logic [7:0] pat_byte(logic [63:0] pat, int i);
        return pat[i*8 +: 8];
    endfunction

    // Longest tail of (first k pattern bytes, c) that is a pattern head, capped at len
    function automatic int prefix_overlap(logic [63:0] pat, int len, int k, logic [7:0] c);
        int         total;
        int         j;
        int         off;
        bit         ok;
        logic [7:0] s;
        total = k + 1;
        j = (total < len) ? total : len;
        while (j > 0) begin
            off = total - j;
            ok = 1'b1;
            for (int i = 0; i < j; i++) begin
                s = (off + i < k) ? pat_byte(pat, off + i) : c;
                if (s != pat_byte(pat, i))
                    ok = 1'b0;
            end
            if (ok)
                return j;
            j--;
        end
        return 0;
    endfunction

    function automatic split_result_t make_result(logic [7:0] b, logic blk, logic cl,
                                                  logic em, logic un);
        return {b, blk, cl, em, un, 1'b0};
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want_v,
                                   input logic [7:0] got_v);
        $display("[%0t] MISMATCH %s: expected %0h, got %0h", $time, what, want_v, got_v);
        fail_count++;
    endtask

    // Work out every result one accepted request causes and queue them
    task automatic predict_results(input logic op, input logic [7:0] c);
        split_result_t burst [0:7];
        int            n;
        int            ls;
        int            le;
        int            k;
        int            ke;
        int            m;
        n  = 0;
        ls = act_len(start_len_reg);
        le = act_len(end_len_reg);
        k  = held_cnt;
        ke = end_cnt;
        // a shortened fence cuts a longer pending match
        if (k >= ls) k = ls - 1;
        if (ke >= le) ke = le - 1;

        if (op == OP_EOS) begin
            // held prefix goes out as text, then the marker
            if (!in_fenced) begin
                for (int i = 0; i < k; i++) begin
                    burst[n] = make_result(pat_byte(start_pat, i), 1'b0, 1'b0, 1'b0, 1'b0);
                    n++;
                end
            end
            burst[n] = make_result(8'h00, 1'b0, 1'b0, 1'b1, in_fenced);
            n++;
            held_cnt  = 0;
            end_cnt   = 0;
            in_fenced = 1'b0;
        end else if (!in_fenced) begin
            m = prefix_overlap(start_pat, ls, k, c);
            if (m == ls) begin
                for (int i = 0; i < k + 1 - ls; i++) begin
                    burst[n] = make_result((i < k) ? pat_byte(start_pat, i) : c,
                                           1'b0, 1'b0, 1'b0, 1'b0);
                    n++;
                end
                for (int i = 0; i < ls; i++) begin
                    burst[n] = make_result(pat_byte(start_pat, i), 1'b1, 1'b0, 1'b0, 1'b0);
                    n++;
                end
                in_fenced = 1'b1;
                held_cnt  = 0;
                end_cnt   = 0;
            end else begin
                for (int i = 0; i < k + 1 - m; i++) begin
                    burst[n] = make_result((i < k) ? pat_byte(start_pat, i) : c,
                                           1'b0, 1'b0, 1'b0, 1'b0);
                    n++;
                end
                held_cnt = m;
            end
        end else begin
            // body byte, possibly the last one of the end fence
            m = prefix_overlap(end_pat, le, ke, c);
            if (m == le) begin
                burst[n] = make_result(c, 1'b1, 1'b1, 1'b0, 1'b0);
                n++;
                in_fenced = 1'b0;
                held_cnt  = 0;
                end_cnt   = 0;
            end else begin
                burst[n] = make_result(c, 1'b1, 1'b0, 1'b0, 1'b0);
                n++;
                end_cnt = m;
            end
        end

        if (n > 0)
            burst[n-1].lst = 1'b1;
        for (int i = 0; i < n; i++)
            expected_q.insert(expected_q.size(), burst[i]);
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic check_result();
        split_result_t want;
        result_total++;
        if (end_marker)
            marker_total++;
        if (block_closed)
            closed_total++;
        if (expected_q.size() == 0) begin
            report_mismatch("result with nothing outstanding, out_byte", 8'h00, out_byte);
        end else begin
            want = expected_q.pop_front();
            if (out_byte != want.data)
                report_mismatch("out_byte", want.data, out_byte);
            if (in_block != want.blk)
                report_mismatch("in_block", 8'(want.blk), 8'(in_block));
            if (block_closed != want.closed)
                report_mismatch("block_closed", 8'(want.closed), 8'(block_closed));
            if (end_marker != want.eos)
                report_mismatch("end_marker", 8'(want.eos), 8'(end_marker));
            if (unterminated != want.unterm)
                report_mismatch("unterminated", 8'(want.unterm), 8'(unterminated));
            if (last != want.lst)
                report_mismatch("last", 8'(want.lst), 8'(last));
        end
    endtask

    // Channel monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_pat     = FENCE_RESET;
            end_pat       = FENCE_RESET;
            start_len_reg = LEN_RESET;
            end_len_reg   = LEN_RESET;
            held_cnt      = 0;
            end_cnt       = 0;
            in_fenced     = 1'b0;
            fail_count    = 0;
            result_total  = 0;
            closed_total  = 0;
            marker_total  = 0;
            expected_q.delete();
            pending      <= 0;
        end else begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_START_FENCE: start_pat     = cfg_data;
                    REG_START_LEN:   start_len_reg = cfg_data[3:0];
                    REG_END_FENCE:   end_pat       = cfg_data;
                    REG_END_LEN:     end_len_reg   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_results(opcode, in_byte);
            pending <= expected_q.size();
        end
    end

endmodule

// File: verif/testbench.sv
// Top of the fenced block stream splitter bench: clock, reset, request and
// register stimulus, result back-pressure and the final verdict.
// Depends on fbss_pkg, fenced_block_stream_splitter and fence_split_checker.
`timescale 1ns / 1ps

module testbench;
    import fbss_pkg::*;

    localparam logic [7:0] BACKQUOTE = 8'h60;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        in_block;
    logic        block_closed;
    logic        end_marker;
    logic        unterminated;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int fail_count;
    int pending;
    int result_total;
    int closed_total;
    int marker_total;

    // Stimulus bookkeeping
    bit          idle_enabled;
    bit          hold_request;
    int          items_sent;
    int          settings_used;
    int          goal;
    logic [63:0] cur_start;
    logic [63:0] cur_end;
    logic [3:0]  cur_slen;
    logic [3:0]  cur_elen;

    always #5 clk = ~clk;

    fenced_block_stream_splitter DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .in_block     (in_block),
        .block_closed (block_closed),
        .end_marker   (end_marker),
        .unterminated (unterminated),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    fence_split_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .in_block     (in_block),
        .block_closed (block_closed),
        .end_marker   (end_marker),
        .unterminated (unterminated),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_total (result_total),
        .closed_total (closed_total),
        .marker_total (marker_total)
    );

    function automatic int fence_span(logic [3:0] len);
        if (len == 4'd0)
            return 1;
        if (int'(len) > FENCE_MAX)
            return FENCE_MAX;
        return int'(len);
    endfunction

    // Fence made of three neighboring characters, so that overlaps are common
    function automatic logic [63:0] narrow_fence();
        logic [63:0] f;
        for (int i = 0; i < 8; i++)
            f[i*8 +: 8] = BACKQUOTE + 8'($urandom_range(0, 2));
        return f;
    endfunction

    // Body and text bytes, biased toward the current fence characters
    function automatic logic [7:0] pick_byte();
        int idx;
        idx = $urandom_range(0, 7);
        case ($urandom_range(0, 4))
            0:       return cur_start[idx*8 +: 8];
            1:       return cur_end[idx*8 +: 8];
            2:       return BACKQUOTE + 8'($urandom_range(0, 2));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One request; valid stays up into the next request unless a gap follows
    task automatic send_item(input logic op, input logic [7:0] b);
        in_valid <= 1'b1;
        opcode   <= op;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (idle_enabled && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic send_data(input logic [7:0] b);
        send_item(OP_DATA, b);
    endtask

    task automatic send_fence(input logic [63:0] pat, input logic [3:0] len);
        for (int i = 0; i < fence_span(len); i++)
            send_data(pat[i*8 +: 8]);
    endtask

    // Stop offering and wait until every outstanding result is out, then idle on
    // for requests that produce nothing
    task automatic drain_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && guard < 50000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Program all four registers while the block is idle
    task automatic load_fences(input logic [63:0] sf, input logic [3:0] sl,
                               input logic [63:0] ef, input logic [3:0] el);
        drain_results();
        write_reg(REG_START_FENCE, sf);
        write_reg(REG_START_LEN, 64'(sl));
        write_reg(REG_END_FENCE, ef);
        write_reg(REG_END_LEN, 64'(el));
        cfg_valid <= 1'b0;
        cur_start = sf;
        cur_slen  = sl;
        cur_end   = ef;
        cur_elen  = el;
        settings_used++;
    endtask

    // One random stretch of the stream, mostly complete fenced blocks
    task automatic send_segment();
        int kind;
        int n;
        int cut;
        kind = $urandom_range(0, 15);
        if (kind <= 8) begin
            n = $urandom_range(0, 3);
            repeat (n) send_data(pick_byte());
            send_fence(cur_start, cur_slen);
            n = $urandom_range(0, 5);
            repeat (n) send_data(pick_byte());
            send_fence(cur_end, cur_elen);
        end else if (kind <= 10) begin
            // broken start fence
            n = fence_span(cur_slen);
            cut = (n > 1) ? $urandom_range(1, n - 1) : 0;
            for (int i = 0; i < cut; i++)
                send_data(cur_start[i*8 +: 8]);
            send_data(pick_byte());
        end else if (kind == 11) begin
            // stream ends inside a block
            send_fence(cur_start, cur_slen);
            n = $urandom_range(0, 3);
            repeat (n) send_data(pick_byte());
            send_item(OP_EOS, 8'($urandom_range(0, 255)));
        end else if (kind == 12) begin
            send_item(OP_EOS, 8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_data(8'($urandom_range(0, 255)));
        end
    endtask

    // Result side: random stalls, and one long hold when asked
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (150) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("fenced_block_stream_splitter verification failed");
        $finish;
    end

    // Main stimulus
    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        opcode    <= OP_DATA;
        in_byte   <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_index <= REG_START_FENCE;
        cfg_data  <= 64'h0;
        idle_enabled  = 1'b1;
        hold_request  = 1'b0;
        items_sent    = 0;
        settings_used = 1;
        cur_start = FENCE_RESET;
        cur_end   = FENCE_RESET;
        cur_slen  = LEN_RESET;
        cur_elen  = LEN_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain text with extreme byte values
        send_data(8'h61);
        send_data(8'hFF);
        send_data(8'h00);
        // two backquotes then a letter: held prefix released as text
        send_data(BACKQUOTE);
        send_data(BACKQUOTE);
        send_data(8'h78);
        // block with a broken end fence inside the body
        send_fence(cur_start, cur_slen);
        send_data(8'h62);
        send_data(BACKQUOTE);
        send_data(BACKQUOTE);
        send_data(8'h63);
        send_fence(cur_end, cur_elen);
        // empty block: start fence directly followed by end fence
        send_fence(cur_start, cur_slen);
        send_fence(cur_end, cur_elen);
        // end of stream with held prefix bytes
        send_data(BACKQUOTE);
        send_data(BACKQUOTE);
        send_item(OP_EOS, 8'hFF);
        // end of stream inside an open block
        send_fence(cur_start, cur_slen);
        send_data(8'h7A);
        send_item(OP_EOS, 8'h00);

        // Held count reaching the length of a shortened start fence
        send_data(BACKQUOTE);
        send_data(BACKQUOTE);
        load_fences(FENCE_RESET, 4'd2, FENCE_RESET, LEN_RESET);
        send_data(8'h71);
        // Overlapping start match: "aaab" against fence "aab"
        load_fences(64'h0062_6161, 4'd3, FENCE_RESET, LEN_RESET);
        send_data(8'h61);
        send_data(8'h61);
        send_data(8'h61);
        send_data(8'h62);
        send_fence(cur_end, cur_elen);
        send_item(OP_EOS, 8'h5A);

        // Random phases, each under its own fence setting
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: load_fences(FENCE_RESET, LEN_RESET, FENCE_RESET, LEN_RESET);
                1: load_fences(narrow_fence(), 4'd1, narrow_fence(), 4'd8);
                2: load_fences(narrow_fence(), 4'd8, narrow_fence(), 4'd8);
                3: load_fences(narrow_fence(), 4'd0, narrow_fence(), 4'd15);
                4: load_fences(64'h0, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
                5: load_fences({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                               {$urandom, $urandom}, 4'($urandom_range(0, 15)));
                default: load_fences(narrow_fence(), 4'($urandom_range(1, 8)),
                                     narrow_fence(), 4'($urandom_range(1, 4)));
            endcase
            idle_enabled = (phase != 3) && (phase != 6);
            // long result-side hold while requests keep coming
            if (phase == 2)
                hold_request = 1'b1;
            goal = items_sent + 48;
            while (items_sent < goal)
                send_segment();
        end

        drain_results();
        repeat (20) @(posedge clk);

        $display("summary: %0d requests, %0d results, %0d blocks closed, %0d stream ends",
                 items_sent, result_total, closed_total, marker_total);
        $display("summary: %0d fence settings, including lengths 0, 1, 8 and 15",
                 settings_used);
        if (pending != 0)
            $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("fenced_block_stream_splitter verification clean");
        else
            $display("fenced_block_stream_splitter verification failed");
        $finish;
    end

endmodule
